[design/point_to_segment_distance_top_defines.svh]
// Assertion macros shared by the point-to-segment distance checker
`ifndef POINT_TO_SEGMENT_DISTANCE_TOP_DEFINES_SVH
`define POINT_TO_SEGMENT_DISTANCE_TOP_DEFINES_SVH

// next-cycle implication, quiet while reset is high
`define PTSD_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("ptsd check failed");

// same-cycle implication, quiet while reset is high
`define PTSD_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("ptsd check failed");

// next-cycle implication that also covers the reset cycles
`define PTSD_ASSERT_RESET(label, pre, post) \
  label: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error("ptsd reset check failed");

`endif

[design/ptsd_pkg.sv]
// Types, widths and case codes for the point-to-segment distance block
package ptsd_pkg;

  localparam int COORD_BITS = 24;
  localparam int CW     = COORD_BITS;
  localparam int DW     = CW + 1;          // coordinate difference
  localparam int PW     = 2 * DW;          // product of two differences
  localparam int DOTW   = PW + 1;          // dot product / cross product
  localparam int CRW    = PW + 1;
  localparam int LENW   = PW;              // squared length, unsigned
  localparam int NUMW   = 2 * CRW;         // radicand numerator
  localparam int RW     = CW + 2;          // root bits resolved by the cell row
  localparam int QW     = RW + LENW;       // root times denominator
  localparam int TW     = NUMW + 2;        // trial value in a cell
  localparam int LO     = CRW / 2;         // low split of |cross|
  localparam int HI     = CRW - LO;
  localparam int BIT_W  = $clog2(RW);
  localparam int DIST_W = CW + 1;

  localparam logic [1:0] CASE_DEGEN    = 2'd0;
  localparam logic [1:0] CASE_START    = 2'd1;
  localparam logic [1:0] CASE_END      = 2'd2;
  localparam logic [1:0] CASE_INTERIOR = 2'd3;

  typedef struct packed {
    logic signed [CW-1:0] start_x;
    logic signed [CW-1:0] start_y;
    logic signed [CW-1:0] end_x;
    logic signed [CW-1:0] end_y;
    logic signed [CW-1:0] query_x;
    logic signed [CW-1:0] query_y;
  } item_t;

  typedef struct packed {
    logic [DIST_W-1:0] dist_res;
    logic [1:0]        nearest_case;
  } result_t;

  // work carried along the root cell row
  typedef struct packed {
    logic [NUMW-1:0] num;
    logic [LENW-1:0] den;
    logic [NUMW-1:0] p;     // d*d*den
    logic [QW-1:0]   q;     // d*den
    logic [RW-1:0]   d;
    logic [1:0]      code;
  } root_t;

endpackage

[design/point_to_segment_distance_top.sv]
// Point-to-segment distance: front end followed by a row of root cells
//
// Channels: query (segment start, segment end, query point) in, result
// (floor distance and nearest-part code) out, each with valid and stall.
// A transfer happens on a clock edge with valid high and stall low.
// Throughput: one query per cycle while the result is not stalled. A query
// passes the front end arithmetic stages (differences, products, sums, case
// choice, radicand) and then a row of 26 cells, one per root bit, each cell
// fixing one bit with a shift-add and compare.
// No state is kept between queries.
// Reset clears all stage valid bits; the block takes queries in the cycle
// after reset ends. When the receiver stalls, the result holds and stages
// behind it keep filling any empty slots; query_stall rises only once every
// stage holds an item.
module point_to_segment_distance_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              query_valid,
  output logic              query_stall,
  input  ptsd_pkg::item_t   query,
  output logic              result_valid,
  input  logic              result_stall,
  output ptsd_pkg::result_t result
);
  import ptsd_pkg::*;

  logic  front_vld;
  root_t front_work;
  logic  cell_vld  [RW];
  logic  cell_en   [RW];
  root_t cell_work [RW];

  ptsd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (query_valid),
    .in_item  (query),
    .in_hold  (query_stall),
    .out_en   (cell_en[0]),
    .out_vld  (front_vld),
    .out_work (front_work)
  );

  // cells from the top root bit down to bit zero
  for (genvar i = 0; i < RW; i++) begin : g_cell
    logic  pv;
    root_t pw;
    logic  ne;
    if (i == 0) begin : g_first
      assign pv = front_vld;
      assign pw = front_work;
    end else begin : g_link
      assign pv = cell_vld[i-1];
      assign pw = cell_work[i-1];
    end
    if (i == RW - 1) begin : g_last
      assign ne = !result_stall;
    end else begin : g_mid
      assign ne = cell_en[i+1];
    end
    ptsd_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .bit_idx   (BIT_W'(RW - 1 - i)),
      .prev_vld  (pv),
      .prev_work (pw),
      .next_en   (ne),
      .en        (cell_en[i]),
      .vld       (cell_vld[i]),
      .work      (cell_work[i])
    );
  end

  assign result_valid        = cell_vld[RW-1];
  assign result.dist_res     = cell_work[RW-1].d[DIST_W-1:0];
  assign result.nearest_case = cell_work[RW-1].code;

endmodule

[design/ptsd_front.sv]
// Geometry front end: differences, products, case choice and radicand
module ptsd_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_vld,
  input  ptsd_pkg::item_t in_item,
  output logic            in_hold,
  input  logic            out_en,
  output logic            out_vld,
  output ptsd_pkg::root_t out_work
);
  import ptsd_pkg::*;

  logic va, vb, vc, vd, ve;
  logic ena, enb, enc, edd, ene;

  // pipeline advance: a stage loads when empty or when the next one loads
  assign ene = !ve || out_en;
  assign edd = !vd || ene;
  assign enc = !vc || edd;
  assign enb = !vb || enc;
  assign ena = !va || enb;
  assign in_hold = !ena;
  assign out_vld = ve;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0; vb <= 1'b0; vc <= 1'b0; vd <= 1'b0; ve <= 1'b0;
    end else begin
      if (ena) va <= in_vld;
      if (enb) vb <= va;
      if (enc) vc <= vb;
      if (edd) vd <= vc;
      if (ene) ve <= vd;
    end
  end

  // stage A: coordinate differences
  logic signed [DW-1:0] a_dx, a_dy, a_vx, a_vy, a_wx, a_wy;
  always_ff @(posedge clk) begin
    if (ena && in_vld) begin
      a_dx <= {in_item.end_x[CW-1], in_item.end_x} - {in_item.start_x[CW-1], in_item.start_x};
      a_dy <= {in_item.end_y[CW-1], in_item.end_y} - {in_item.start_y[CW-1], in_item.start_y};
      a_vx <= {in_item.query_x[CW-1], in_item.query_x}
              - {in_item.start_x[CW-1], in_item.start_x};
      a_vy <= {in_item.query_y[CW-1], in_item.query_y}
              - {in_item.start_y[CW-1], in_item.start_y};
      a_wx <= {in_item.query_x[CW-1], in_item.query_x} - {in_item.end_x[CW-1], in_item.end_x};
      a_wy <= {in_item.query_y[CW-1], in_item.query_y} - {in_item.end_y[CW-1], in_item.end_y};
    end
  end

  // stage B: all products in parallel
  logic signed [PW-1:0] b_vdx, b_vdy, b_dxx, b_dyy, b_dxvy, b_dyvx;
  logic signed [PW-1:0] b_vxx, b_vyy, b_wxx, b_wyy;
  logic                 b_deg;
  always_ff @(posedge clk) begin
    if (enb && va) begin
      b_vdx  <= a_vx * a_dx;
      b_vdy  <= a_vy * a_dy;
      b_dxx  <= a_dx * a_dx;
      b_dyy  <= a_dy * a_dy;
      b_dxvy <= a_dx * a_vy;
      b_dyvx <= a_dy * a_vx;
      b_vxx  <= a_vx * a_vx;
      b_vyy  <= a_vy * a_vy;
      b_wxx  <= a_wx * a_wx;
      b_wyy  <= a_wy * a_wy;
      b_deg  <= (a_dx == '0) && (a_dy == '0);
    end
  end

  // stage C: dot, squared length, cross and endpoint distances
  logic signed [DOTW-1:0] c_dot;
  logic signed [CRW-1:0]  c_cross;
  logic [LENW-1:0]        c_len2, c_sv, c_se;
  logic                   c_deg;
  always_ff @(posedge clk) begin
    if (enc && vb) begin
      c_dot   <= {b_vdx[PW-1], b_vdx} + {b_vdy[PW-1], b_vdy};
      c_cross <= {b_dxvy[PW-1], b_dxvy} - {b_dyvx[PW-1], b_dyvx};
      c_len2  <= b_dxx + b_dyy;
      c_sv    <= b_vxx + b_vyy;
      c_se    <= b_wxx + b_wyy;
      c_deg   <= b_deg;
    end
  end

  // stage D: case decision and partial products of cross squared
  logic [1:0]       code_c;
  logic [CRW-1:0]   mag_c;
  logic [1:0]       d_code;
  logic [LENW-1:0]  d_len2, d_small;
  logic [2*HI-1:0]  d_hh;
  logic [HI+LO-1:0] d_hl;
  logic [2*LO-1:0]  d_ll;

  always_comb begin
    if (c_deg) code_c = CASE_DEGEN;
    else if (c_dot[DOTW-1]) code_c = CASE_START;
    else if (c_dot > $signed({1'b0, c_len2})) code_c = CASE_END;
    else code_c = CASE_INTERIOR;
    mag_c = c_cross[CRW-1] ? CRW'(-c_cross) : CRW'(c_cross);
  end

  always_ff @(posedge clk) begin
    if (edd && vc) begin
      d_code  <= code_c;
      d_len2  <= c_len2;
      d_small <= (code_c == CASE_END) ? c_se : c_sv;
      d_hh    <= mag_c[CRW-1:LO] * mag_c[CRW-1:LO];
      d_hl    <= mag_c[CRW-1:LO] * mag_c[LO-1:0];
      d_ll    <= mag_c[LO-1:0] * mag_c[LO-1:0];
    end
  end

  // stage E: radicand and denominator
  logic [NUMW-1:0] num_d;
  assign num_d = (NUMW'(d_hh) << (2 * LO)) + (NUMW'(d_hl) << (LO + 1)) + NUMW'(d_ll);

  always_ff @(posedge clk) begin
    if (ene && vd) begin
      out_work.code <= d_code;
      out_work.num  <= (d_code == CASE_INTERIOR) ? num_d : NUMW'(d_small);
      out_work.den  <= (d_code == CASE_INTERIOR) ? d_len2 : LENW'(1);
      out_work.p    <= '0;
      out_work.q    <= '0;
      out_work.d    <= '0;
    end
  end

endmodule

[design/ptsd_cell.sv]
// One root cell: decides one bit of floor(sqrt(num/den)) and hands on
module ptsd_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [ptsd_pkg::BIT_W-1:0] bit_idx,
  input  logic                      prev_vld,
  input  ptsd_pkg::root_t           prev_work,
  input  logic                      next_en,
  output logic                      en,
  output logic                      vld,
  output ptsd_pkg::root_t           work
);
  import ptsd_pkg::*;

  logic [TW-1:0] trial;
  logic          take;

  // (d + 2^b)^2 * den = p + q*2^(b+1) + den*2^(2b)
  assign trial = TW'(prev_work.p) + (TW'(prev_work.q) << (bit_idx + 1'b1))
                 + (TW'(prev_work.den) << {bit_idx, 1'b0});
  assign take  = trial <= TW'(prev_work.num);
  assign en    = !vld || next_en;

  always_ff @(posedge clk) begin
    if (rst) vld <= 1'b0;
    else if (en) vld <= prev_vld;
  end

  always_ff @(posedge clk) begin
    if (en && prev_vld) begin
      work.num  <= prev_work.num;
      work.den  <= prev_work.den;
      work.code <= prev_work.code;
      if (take) begin
        work.p <= trial[NUMW-1:0];
        work.q <= prev_work.q + (QW'(prev_work.den) << bit_idx);
        work.d <= prev_work.d | (RW'(1) << bit_idx);
      end else begin
        work.p <= prev_work.p;
        work.q <= prev_work.q;
        work.d <= prev_work.d;
      end
    end
  end

endmodule

[design/ptsd_checker.sv]
// Port-level checks for the point-to-segment distance block, with bind
`include "point_to_segment_distance_top_defines.svh"

module ptsd_checker (
  input logic              clk,
  input logic              rst,
  input logic              query_valid,
  input logic              query_stall,
  input ptsd_pkg::item_t   query,
  input logic              result_valid,
  input logic              result_stall,
  input ptsd_pkg::result_t result
);
  import ptsd_pkg::*;

  // a held result stays put
  `PTSD_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(result))
  // back pressure on queries only comes from a backed-up result
  `PTSD_ASSERT_NOW(a_stall_cause, query_stall, result_valid && result_stall)
  // reset empties the pipeline
  `PTSD_ASSERT_RESET(a_reset_empty, rst, !result_valid && !query_stall)

endmodule

bind point_to_segment_distance_top ptsd_checker u_ptsd_checker (.*);

[tb/tb.sv]
// Testbench for the point-to-segment distance block: scoreboard class and stimulus
`timescale 1ns / 1ps

module tb;
  import ptsd_pkg::*;

  // Predicts distance and case per query and checks results in order
  class dist_scoreboard;
    result_t pending[$];
    int      errors = 0;

    // largest d with d*d*den <= num
    static function logic [DIST_W-1:0] floor_root(logic [159:0] num, logic [159:0] den);
      logic [63:0]  d;
      logic [63:0]  cand;
      logic [191:0] sq;
      d = '0;
      for (int b = CW + 1; b >= 0; b--) begin
        cand = d | (64'd1 << b);
        sq = cand * cand * den;
        if (sq <= num) d = cand;
      end
      return d[DIST_W-1:0];
    endfunction

    function void note_query(item_t q);
      longint sx, sy, ex, ey, qx, qy, dx, dy, vx, vy, crs;
      logic signed [127:0] dot, len2;
      logic [159:0] num, den;
      result_t r;
      sx = longint'(q.start_x); sy = longint'(q.start_y);
      ex = longint'(q.end_x); ey = longint'(q.end_y);
      qx = longint'(q.query_x); qy = longint'(q.query_y);
      dx = ex - sx; dy = ey - sy; vx = qx - sx; vy = qy - sy;
      den = 160'd1;
      if (dx == 0 && dy == 0) begin
        r.nearest_case = CASE_DEGEN;
        num = 160'(vx * vx + vy * vy);
      end else begin
        dot  = 128'(vx) * 128'(dx) + 128'(vy) * 128'(dy);
        len2 = 128'(dx) * 128'(dx) + 128'(dy) * 128'(dy);
        if (dot < 0) begin
          r.nearest_case = CASE_START;
          num = 160'(vx * vx + vy * vy);
        end else if (dot > len2) begin
          r.nearest_case = CASE_END;
          num = 160'((qx - ex) * (qx - ex) + (qy - ey) * (qy - ey));
        end else begin
          r.nearest_case = CASE_INTERIOR;
          crs = dx * vy - dy * vx;
          num = 160'(crs < 0 ? -crs : crs);
          num = num * num;
          den = 160'(len2);
        end
      end
      r.dist_res = floor_root(num, den);
      pending.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t exp_r;
      if (pending.size() == 0) begin
        $error("unexpected result dist_res=%0d nearest_case=%0d",
               got.dist_res, got.nearest_case);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.dist_res !== exp_r.dist_res) begin
        $error("dist_res expected %0d actual %0d", exp_r.dist_res, got.dist_res);
        errors++;
      end
      if (got.nearest_case !== exp_r.nearest_case) begin
        $error("nearest_case expected %0d actual %0d", exp_r.nearest_case,
               got.nearest_case);
        errors++;
      end
    endfunction
  endclass

  localparam int LATENCY   = 31;
  localparam int WATCHDOG  = 5000;
  localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

  logic    clk = 0;
  logic    rst = 1;
  logic    query_valid = 0;
  logic    query_stall;
  item_t   query = '0;
  logic    result_valid;
  logic    result_stall = 0;
  result_t result;

  dist_scoreboard sb = new();
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_off = 0;
  int  idle_cycles = 0;

  point_to_segment_distance_top dut (
    .clk, .rst, .query_valid, .query_stall, .query,
    .result_valid, .result_stall, .result
  );

  always #10 clk = ~clk;

  // result side: check each transfer, stall at random or during a hold-off
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && !result_stall) sb.check_result(result);
      if ((query_valid && !query_stall) || (result_valid && !result_stall))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      result_stall <= hold_off || ($urandom_range(99) < recv_stall_pct);
    end
  end

  // timeout on a long stretch with no transfer
  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // offer one query, with random idle cycles in front, until it transfers
  task automatic send_query(item_t q);
    while ($urandom_range(99) < send_idle_pct) begin
      query_valid <= 0;
      @(posedge clk);
    end
    query_valid <= 1;
    query <= q;
    @(posedge clk);
    while (query_stall) @(posedge clk);
    sb.note_query(q);
  endtask

  function automatic logic signed [CW-1:0] rand_coord();
    case ($urandom_range(3))
      0: return CW'($urandom);
      1: return CW'($urandom_range(0, 40) - 20);
      2: return $urandom_range(1) ? CW'(CMAX - $urandom_range(3))
                                  : CW'(CMIN + $urandom_range(3));
      default: return CW'($signed($urandom_range(0, 4000)) - 2000);
    endcase
  endfunction

  function automatic item_t rand_query();
    item_t q;
    q.start_x = rand_coord(); q.start_y = rand_coord();
    q.query_x = rand_coord(); q.query_y = rand_coord();
    if ($urandom_range(9) == 0) begin
      q.end_x = q.start_x; q.end_y = q.start_y;
    end else begin
      q.end_x = rand_coord(); q.end_y = rand_coord();
    end
    return q;
  endfunction

  function automatic item_t mk(int sx, int sy, int ex, int ey, int qx, int qy);
    item_t q;
    q.start_x = CW'(sx); q.start_y = CW'(sy); q.end_x = CW'(ex); q.end_y = CW'(ey);
    q.query_x = CW'(qx); q.query_y = CW'(qy);
    return q;
  endfunction

  task automatic drain();
    query_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    item_t dq[$];
    repeat (2) @(posedge clk);
    rst <= 0;

    // directed: degenerate, each side, exact ends, extremes
    dq.push_back(mk(0, 0, 0, 0, 0, 0));
    dq.push_back(mk(5, 5, 5, 5, 8, 9));
    dq.push_back(mk(CMIN, CMIN, CMIN, CMIN, CMAX, CMAX));
    dq.push_back(mk(0, 0, 10, 0, -3, 4));
    dq.push_back(mk(0, 0, 10, 0, 13, 4));
    dq.push_back(mk(0, 0, 10, 0, 0, 7));
    dq.push_back(mk(0, 0, 10, 0, 10, 7));
    dq.push_back(mk(0, 0, 10, 0, 5, -7));
    dq.push_back(mk(0, 0, 10, 0, 5, 0));
    dq.push_back(mk(CMIN, CMIN, CMAX, CMAX, CMIN, CMAX));
    dq.push_back(mk(CMIN, CMAX, CMAX, CMIN, CMAX, CMAX));
    dq.push_back(mk(CMIN, 0, CMAX, 0, 0, CMIN));
    dq.push_back(mk(CMIN, CMIN, CMIN + 1, CMIN, CMAX, CMAX));
    dq.push_back(mk(CMAX, CMAX, CMAX - 1, CMAX, CMIN, CMIN));
    dq.push_back(mk(-1, -1, -1, -1, -1, -1));
    dq.push_back(mk(CMAX, CMIN, CMIN, CMAX, CMIN, CMIN));
    dq.push_back(mk(1, 2, 4, 6, 3, 3));
    foreach (dq[i]) send_query(dq[i]);

    // random phases with different idling mixes
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1 || ph == 3) ? (ph == 3 ? 38 : 45) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 3 ? 38 : 45) : 0;
      repeat (140) send_query(rand_query());
      if (ph == 1) begin
        // sender pauses until every result is back
        drain();
      end
    end

    // long receiver hold-off while queries keep coming
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      begin
        hold_off = 1;
        repeat (120) @(posedge clk);
        hold_off = 0;
      end
      repeat (70) send_query(rand_query());
    join

    drain();
    repeat (LATENCY + 10) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule
